### hdl/mcc_pkg.sv
package mcc_pkg;

    localparam int AMOUNT_W  = 10;   // target / count width
    localparam int COIN_REGS = 6;    // denomination registers
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int COIN_N_W  = 3;    // holds 0..COIN_REGS

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_5 = 3'd6;

    // one table entry: reachable flag over the coin count
    typedef struct packed {
        logic                reach;
        logic [AMOUNT_W-1:0] count;
    } t_entry;

    typedef logic [COIN_REGS-1:0][AMOUNT_W-1:0] t_coin_arr;

endpackage

### hdl/mcc_table.sv
module mcc_table
    import mcc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    // contents undefined until written; every read whose data is used is preceded by a write
    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/mcc_ctrl.sv
module mcc_ctrl
    import mcc_pkg::*;
#(
    parameter int MAX_AMOUNT = 1023,
    parameter int AW         = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transaction
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [AMOUNT_W-1:0] i_target,
    // result transaction
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_entry              o_out,
    // coin set
    input  logic [COIN_N_W-1:0] i_coin_n,
    input  t_coin_arr           i_coin_values,
    // table port
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output t_entry              o_wr_data,
    output logic [AW-1:0]       o_rd_addr,
    input  t_entry              i_rd_data
);

    typedef enum logic [1:0] {S_IDLE, S_INIT, S_SCAN, S_DONE} t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_target, n_target;
    logic [AW-1:0]       r_i, n_i;
    logic [COIN_N_W-1:0] r_k, n_k;
    logic                r_pend, n_pend;
    logic                r_found, n_found;
    logic [AMOUNT_W-1:0] r_best, n_best;
    t_entry              r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_entry              r_out, n_out;

    logic                m_found;
    logic [AMOUNT_W-1:0] m_best;
    logic [AMOUNT_W-1:0] coin_v;
    logic                coin_ok;
    t_entry              new_entry;

    // fold the entry read last cycle into the running minimum
    always_comb begin
        m_found = r_found;
        m_best  = r_best;
        if (r_pend && i_rd_data.reach && (!r_found || i_rd_data.count < r_best)) begin
            m_found = 1'b1;
            m_best  = i_rd_data.count;
        end
    end

    always_comb begin
        coin_v  = i_coin_values[r_k];
        coin_ok = (coin_v != '0) && ({{(AW+AMOUNT_W){1'b0}}, coin_v}
                  <= {{AMOUNT_W{1'b0}}, {AMOUNT_W{1'b0}}, r_i});
        new_entry.reach = m_found;
        new_entry.count = m_found ? m_best + AMOUNT_W'(1) : '0;
    end

    always_comb begin
        n_state     = r_state;
        n_target    = r_target;
        n_i         = r_i;
        n_k         = r_k;
        n_pend      = 1'b0;
        n_found     = r_found;
        n_best      = r_best;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_i;
        o_wr_data   = new_entry;
        o_rd_addr   = r_i - AW'(coin_v);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (32'(i_target) > MAX_AMOUNT) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else if (i_target == '0) begin
                        n_res   = '{reach: 1'b1, count: '0};
                        n_state = S_DONE;
                    end else begin
                        n_target = AW'(i_target);
                        n_state  = S_INIT;
                    end
                end
            end
            S_INIT: begin
                // base entry: zero coins make amount zero
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = '{reach: 1'b1, count: '0};
                n_i       = AW'(1);
                n_k       = '0;
                n_found   = 1'b0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (r_k < i_coin_n) begin
                    n_pend  = coin_ok;
                    n_k     = r_k + COIN_N_W'(1);
                    n_found = m_found;
                    n_best  = m_best;
                end else begin
                    o_wr_en = 1'b1;
                    if (r_i == r_target) begin
                        n_res   = new_entry;
                        n_state = S_DONE;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_k     = '0;
                        n_found = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_target <= n_target;
        r_i      <= n_i;
        r_k      <= n_k;
        r_found  <= n_found;
        r_best   <= n_best;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hdl/min_coin_change_dp.sv
// Channel   Dir  Handshake                      Payload (lowest bit up)
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: target_amount[9:0], pad to 16
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: fewest_coins[9:0], pad; tuser: reachable
// cfg       in   i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// The table is filled for every amount from 1 up to the target T; each amount
// costs one table read per active coin on the single read port, plus a table
// write-back. Zero or over-range targets skip the table and go straight to
// S_DONE. s_axis is ready again from the cycle the result appears on m_axis.
// Reset (synchronous, active low) clears control and loads the register
// defaults; the table needs no clearing. A result held on m_axis does not
// block the next transaction from being accepted and worked on; that item's
// result waits until m_axis has drained.

module min_coin_change_dp
    import mcc_pkg::*;
#(
    parameter int MAX_AMOUNT = 1023,
    parameter int MAX_COINS  = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,  // target_amount[9:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,  // fewest_coins[9:0]
    output logic                 o_m_axis_tuser,  // reachable
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [COIN_N_W-1:0] r_coin_count;
    t_coin_arr           r_coin_values;
    logic [COIN_N_W-1:0] coin_n;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_entry        wr_data, rd_data, out_entry;

    // configuration registers; indexes past the last coin are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin_count <= '0;
            for (int j = 0; j < COIN_REGS; j++) begin
                r_coin_values[j] <= AMOUNT_W'(1);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index) inside
                CFG_COIN_COUNT: r_coin_count <= i_cfg_data[COIN_N_W-1:0];
                [CFG_COIN_VALUE_0:CFG_COIN_VALUE_5]:
                    r_coin_values[i_cfg_index - CFG_COIN_VALUE_0] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coin counts beyond the build limit act as the limit
    assign coin_n = (r_coin_count > COIN_N_W'(MAX_COINS)) ? COIN_N_W'(MAX_COINS)
                                                          : r_coin_count;

    mcc_ctrl #(
        .MAX_AMOUNT (MAX_AMOUNT),
        .AW         (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_target      (i_s_axis_tdata[AMOUNT_W-1:0]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out         (out_entry),
        .i_coin_n      (coin_n),
        .i_coin_values (r_coin_values),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    mcc_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_m_axis_tdata = {{(16-AMOUNT_W){1'b0}}, out_entry.count};
    assign o_m_axis_tuser = out_entry.reach;

endmodule
